@@ src/bounded_word_set_core_defines.svh @@
// Assertion macros for the bounded word set core.
// Included by the top level; expects clk and rst_n in scope.
`ifndef BOUNDED_WORD_SET_CORE_DEFINES_SVH
`define BOUNDED_WORD_SET_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BWSET_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define BWSET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bwset_pkg.sv @@
// Shared types and constants for the bounded word set core.
// No dependencies; imported by the controller, datapath and top level.
package bwset_pkg;

  localparam int CAPACITY = 32;
  localparam int WORD_W   = 32;
  localparam int KIND_W   = 3;
  localparam int IDX_W    = 5;
  localparam int CNTO_W   = 6;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int POS_W    = $clog2(CAPACITY);
  localparam int CMP_W    = (COUNT_W > IDX_W) ? COUNT_W : IDX_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_TEST   = 3'd2,
    KIND_READ   = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic cmp;
    logic commit;
  } dp_cmd_t;

endpackage

@@ src/bwset_ctrl.sv @@
// Controller for the bounded word set core: sequences compare and commit.
// Depends on bwset_pkg; drives the datapath through dp_cmd_t.
module bwset_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bwset_pkg::dp_cmd_t cmd
);
  import bwset_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   commit;

  // Hold state and result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    commit     = (state_r == ST_APPLY) && (!out_valid_r || out_ready);
    in_ready   = (state_r == ST_IDLE) || commit;
    cmd.load   = in_valid && in_ready;
    cmd.cmp    = (state_r == ST_CMP);
    cmd.commit = commit;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (commit) state_nxt = in_valid ? ST_CMP : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // Load a new result on commit, drop it when taken
    if (commit)         out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

@@ src/bwset_dp.sv @@
// Datapath for the bounded word set core: member cells, compare, result.
// Depends on bwset_pkg; driven by commands from bwset_ctrl.
module bwset_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bwset_pkg::dp_cmd_t                cmd,
  input  logic [bwset_pkg::KIND_W-1:0]      in_kind,
  input  logic [bwset_pkg::WORD_W-1:0]      in_value,
  input  logic [bwset_pkg::IDX_W-1:0]       in_index,
  output logic                              out_found,
  output logic [bwset_pkg::WORD_W-1:0]      out_member_out,
  output logic [bwset_pkg::CNTO_W-1:0]      out_count_out,
  output logic [bwset_pkg::STAT_W-1:0]      out_status
);
  import bwset_pkg::*;

  // Request registers
  logic [KIND_W-1:0]   kind_r;
  logic [WORD_W-1:0]   value_r;
  logic [IDX_W-1:0]    index_r;

  // Member cells and count
  logic [WORD_W-1:0]   store_r   [CAPACITY];
  logic [WORD_W-1:0]   store_nxt [CAPACITY];
  logic [COUNT_W-1:0]  count_r, count_nxt;

  // First matching cell, one-hot
  logic [CAPACITY-1:0] hit;
  logic [CAPACITY-1:0] first_r, first_nxt;

  // Result registers
  logic                found_r, found_nxt;
  logic [WORD_W-1:0]   member_r, member_nxt;
  logic [STAT_W-1:0]   status_r, status_nxt;

  logic [CAPACITY-1:0] shift_mask;
  logic                present;
  logic                add_en, shift_en;
  logic [POS_W-1:0]    add_pos;
  logic [POS_W-1:0]    rd_pos;

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      value_r <= in_value;
      index_r <= in_index;
    end
  end

  // Compare every live cell against the request word, keep the first hit
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      hit[i] = (store_r[i] == value_r) && (COUNT_W'(i) < count_r);
    end
    first_nxt = hit & (~hit + CAPACITY'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp) first_r <= first_nxt;
  end

  // Work out the update and the result
  always_comb begin
    present    = |first_r;
    shift_mask = ~(first_r - CAPACITY'(1));
    add_pos    = POS_W'(count_r);
    rd_pos     = POS_W'(index_r);
    add_en     = 1'b0;
    shift_en   = 1'b0;
    count_nxt  = count_r;
    found_nxt  = 1'b0;
    member_nxt = '0;
    status_nxt = STAT_OK;
    case (kind_r)
      KIND_ADD: begin
        if (present) begin
          found_nxt = 1'b1;
        end else if (count_r == COUNT_W'(CAPACITY)) begin
          status_nxt = STAT_FULL;
        end else begin
          add_en    = 1'b1;
          count_nxt = count_r + COUNT_W'(1);
        end
      end
      KIND_REMOVE: begin
        if (present) begin
          found_nxt = 1'b1;
          shift_en  = 1'b1;
          count_nxt = count_r - COUNT_W'(1);
        end
      end
      KIND_TEST: begin
        found_nxt = present;
      end
      KIND_READ: begin
        if (CMP_W'(index_r) < CMP_W'(count_r)) member_nxt = store_r[rd_pos];
        else                                  status_nxt = STAT_RANGE;
      end
      KIND_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    // Append at the tail, or close the gap left by a removed word
    for (int j = 0; j < CAPACITY; j++) begin
      store_nxt[j] = store_r[j];
      if (add_en && (add_pos == POS_W'(j))) begin
        store_nxt[j] = value_r;
      end else if (shift_en && shift_mask[j] && (j < CAPACITY - 1)) begin
        store_nxt[j] = store_r[(j < CAPACITY - 1) ? j + 1 : j];
      end
    end
  end

  // Commit cells and result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int j = 0; j < CAPACITY; j++) store_r[j] <= store_nxt[j];
      found_r  <= found_nxt;
      member_r <= member_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          count_r <= '0;
    else if (cmd.commit) count_r <= count_nxt;
  end

  assign out_found      = found_r;
  assign out_member_out = member_r;
  assign out_status     = status_r;

  // Count after the last committed request
  assign out_count_out  = CNTO_W'(count_r);

endmodule

@@ src/bounded_word_set_core.sv @@
// Top level of the bounded word set core: controller plus datapath.
// Depends on bwset_pkg, bwset_ctrl, bwset_dp and the assertion header.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   in_kind, in_value, in_index
//   out_     output     out_valid / out_ready out_found, out_member_out,
//                                             out_count_out, out_status
//
// Each request passes through a compare state, which checks the word against all
// member cells in parallel, and an apply state, which commits the add, shift or read into the cells.
// A new request can be taken in the commit cycle, while the previous one commits.
// Reset clears the count and the control; cells hold junk until written.
// The result register holds one finished result; commit waits while it is
// still full and not being taken.
`include "bounded_word_set_core_defines.svh"

module bounded_word_set_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bwset_pkg::KIND_W-1:0]  in_kind,
  input  logic [bwset_pkg::WORD_W-1:0]  in_value,
  input  logic [bwset_pkg::IDX_W-1:0]   in_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_found,
  output logic [bwset_pkg::WORD_W-1:0]  out_member_out,
  output logic [bwset_pkg::CNTO_W-1:0]  out_count_out,
  output logic [bwset_pkg::STAT_W-1:0]  out_status
);
  import bwset_pkg::*;

  dp_cmd_t cmd;

  bwset_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  bwset_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_kind        (in_kind),
    .in_value       (in_value),
    .in_index       (in_index),
    .out_found      (out_found),
    .out_member_out (out_member_out),
    .out_count_out  (out_count_out),
    .out_status     (out_status)
  );

  // A dropped add only happens with the set at capacity
  `BWSET_ASSERT_NOW(a_full_at_cap, out_valid && (out_status == STAT_FULL), (out_count_out == CNTO_W'(CAPACITY)) && !out_found, "full status without a full set")
  // A rejected read returns no word
  `BWSET_ASSERT_NOW(a_range_zero, out_valid && (out_status == STAT_RANGE), (out_member_out == '0) && !out_found, "range status with data")
  // Accepted request keeps the core busy through its compare cycle
  `BWSET_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request taken during compare")

endmodule
